[hw/rtl/mvsm_pkg.sv]
package mvsm_pkg;

    // Item kinds carried on s_axis_tuser
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_GAIN  = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_TICK  = 3'd4;
    localparam logic [2:0] ACT_QUERY = 3'd5;

    // Fixed-point format of position and step
    localparam int FRAC_BITS   = 16;
    localparam int OUTPUT_RATE = 11025;
    // Largest step: 65535 * 2^16 / 11025 fits in 20 bits
    localparam int STEP_W      = 20;

    // floor(rate * 2^16 / 11025) == (rate * STEP_K) >> STEP_SHIFT, exact for rate < 110855
    localparam int STEP_SHIFT         = 29;
    localparam logic [31:0] STEP_K    = 32'd3191326267;
    localparam int STEP_PROD_W        = 49;

    // Sample centering and output limits
    localparam logic [7:0] SILENCE = 8'd128;
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    // floor(x / 127) == (x * RECIP_K) >> RECIP_SHIFT, exact for x < 4294967
    localparam int RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_K = 23'd4227331;
    localparam int PROD_W = 46;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mem_wr;
        logic start_wr;
        logic gain_wr;
        logic stop_wr;
        logic div_init;
        logic walk_clr;
        logic walk_issue;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] act;
        logic       walk_last;
        logic       pipe_busy;
        logic       out_free;
    } sts_t;

endpackage

[hw/rtl/mvsm_ctrl.sv]
module mvsm_ctrl
    import mvsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_RES   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.act)
                    ACT_LOAD:
                    begin
                        cmd.mem_wr = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ACT_START:
                    begin
                        cmd.div_init = 1'b1;
                        state_next   = ST_START;
                    end
                    ACT_GAIN:
                    begin
                        cmd.gain_wr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    ACT_STOP:
                    begin
                        cmd.stop_wr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    ACT_TICK:
                    begin
                        cmd.walk_clr = 1'b1;
                        state_next   = ST_WALK;
                    end
                    ACT_QUERY:
                    begin
                        state_next = ST_RES;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_START:
            begin
                cmd.start_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_WALK:
            begin
                cmd.walk_issue = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/mvsm_dpath.sv]
module mvsm_dpath
    import mvsm_pkg::*;
#(
    parameter int VOICES      = 32,
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [2:0]  in_act,
    input  logic [4:0]  in_voice,
    input  logic [11:0] in_sidx,
    input  logic [7:0]  in_sbyte,
    input  logic [12:0] in_slen,
    input  logic [15:0] in_srate,
    input  logic [6:0]  in_lg,
    input  logic [6:0]  in_rg,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [15:0] out_left,
    output logic [15:0] out_right,
    output logic        out_is_frame,
    output logic [31:0] out_mask
);

    localparam int VI_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SI_W   = $clog2(MAX_SAMPLES);
    localparam int LEN_W  = SI_W + 1;
    localparam int INT_W  = SI_W + 2;
    localparam int POS_W  = INT_W + FRAC_BITS;
    localparam int DEPTH  = VOICES * MAX_SAMPLES;
    localparam int AW     = $clog2(DEPTH);
    localparam int ACC_W  = 17 + VI_W;

    // Captured transaction
    logic [2:0]  act_reg;
    logic [4:0]  voice_reg;
    logic [11:0] sidx_reg;
    logic [7:0]  sbyte_reg;
    logic [12:0] slen_reg;
    logic [15:0] srate_reg;
    logic [6:0]  lg_reg;
    logic [6:0]  rg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= in_act;
            voice_reg <= in_voice;
            sidx_reg  <= in_sidx;
            sbyte_reg <= in_sbyte;
            slen_reg  <= in_slen;
            srate_reg <= in_srate;
            lg_reg    <= in_lg;
            rg_reg    <= in_rg;
        end
    end

    logic            voice_ok;
    logic [VI_W-1:0] vidx;
    logic [LEN_W-1:0] slen_cap;

    assign voice_ok = (32'(voice_reg) < VOICES);
    assign vidx     = voice_reg[VI_W-1:0];
    assign slen_cap = (32'(slen_reg) > MAX_SAMPLES) ? LEN_W'(MAX_SAMPLES) : LEN_W'(slen_reg);

    // Step: (rate << FRAC_BITS) / OUTPUT_RATE by reciprocal multiply, registered
    logic [STEP_W-1:0]      div_q_reg;
    logic [STEP_PROD_W-1:0] step_prod;

    assign step_prod = STEP_PROD_W'(srate_reg) * STEP_PROD_W'(STEP_K);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            div_q_reg <= step_prod[STEP_SHIFT +: STEP_W];
        end
    end

    // Per-voice state
    logic              active_reg [VOICES];
    logic [POS_W-1:0]  pos_reg    [VOICES];
    logic [STEP_W-1:0] step_reg   [VOICES];
    logic [LEN_W-1:0]  len_reg    [VOICES];
    logic [6:0]        llev_reg   [VOICES];
    logic [6:0]        rlev_reg   [VOICES];

    // Walk counter and stage A lookup
    logic [VI_W-1:0]  cnt_reg;
    logic             a_act;
    logic [POS_W-1:0] a_pos;
    logic [INT_W-1:0] a_int;
    logic             a_hit;
    logic             a_play;

    assign a_act  = active_reg[cnt_reg];
    assign a_pos  = pos_reg[cnt_reg];
    assign a_int  = a_pos[POS_W-1:FRAC_BITS];
    assign a_hit  = a_act && (a_int >= INT_W'(len_reg[cnt_reg]));
    assign a_play = a_act && !a_hit;

    logic start_ok;
    assign start_ok = cmd.start_wr && voice_ok && (slen_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                active_reg[v] <= 1'b0;
                pos_reg[v]    <= '0;
                step_reg[v]   <= '0;
                len_reg[v]    <= '0;
                llev_reg[v]   <= '0;
                rlev_reg[v]   <= '0;
            end
        end
        else
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                if (start_ok && (vidx == VI_W'(v)))
                begin
                    active_reg[v] <= 1'b1;
                    pos_reg[v]    <= '0;
                    step_reg[v]   <= div_q_reg;
                    len_reg[v]    <= slen_cap;
                    llev_reg[v]   <= lg_reg;
                    rlev_reg[v]   <= rg_reg;
                end
                if (cmd.gain_wr && voice_ok && (vidx == VI_W'(v)))
                begin
                    llev_reg[v] <= lg_reg;
                    rlev_reg[v] <= rg_reg;
                end
                if (cmd.stop_wr && voice_ok && (vidx == VI_W'(v)))
                begin
                    active_reg[v] <= 1'b0;
                end
                if (cmd.walk_issue && (cnt_reg == VI_W'(v)))
                begin
                    if (a_hit)
                    begin
                        active_reg[v] <= 1'b0;
                    end
                    if (a_play)
                    begin
                        pos_reg[v] <= a_pos + POS_W'(step_reg[v]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.walk_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.walk_issue)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Sample store
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign mem_we  = cmd.mem_wr && voice_ok && (32'(sidx_reg) < MAX_SAMPLES);
    assign wr_addr = AW'(vidx) * AW'(MAX_SAMPLES) + AW'(sidx_reg);
    assign rd_addr = AW'(cnt_reg) * AW'(MAX_SAMPLES) + AW'(a_pos[FRAC_BITS +: SI_W]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= sbyte_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Stage B: center the sample and scale by the gains
    logic       b_vld_reg;
    logic [6:0] b_lg_reg;
    logic [6:0] b_rg_reg;
    logic       b_neg;
    logic [7:0] b_mag;

    always_ff @(posedge clk)
    begin
        b_lg_reg <= llev_reg[cnt_reg];
        b_rg_reg <= rlev_reg[cnt_reg];
    end

    assign b_neg = (rd_data_reg < SILENCE);
    assign b_mag = b_neg ? (SILENCE - rd_data_reg) : (rd_data_reg - SILENCE);

    // Stage C: divide by unity gain through the reciprocal
    logic        c_vld_reg;
    logic        c_neg_reg;
    logic [14:0] c_ml_reg;
    logic [14:0] c_mr_reg;
    logic [PROD_W-1:0] c_pl;
    logic [PROD_W-1:0] c_pr;

    always_ff @(posedge clk)
    begin
        c_neg_reg <= b_neg;
        c_ml_reg  <= 15'(b_mag * b_lg_reg);
        c_mr_reg  <= 15'(b_mag * b_rg_reg);
    end

    assign c_pl = PROD_W'({c_ml_reg, 8'd0}) * PROD_W'(RECIP_K);
    assign c_pr = PROD_W'({c_mr_reg, 8'd0}) * PROD_W'(RECIP_K);

    // Stage D: signed accumulate
    logic        d_vld_reg;
    logic        d_neg_reg;
    logic [15:0] d_ql_reg;
    logic [15:0] d_qr_reg;
    logic signed [ACC_W-1:0] accl_reg;
    logic signed [ACC_W-1:0] accr_reg;
    logic signed [ACC_W-1:0] d_tl;
    logic signed [ACC_W-1:0] d_tr;

    always_ff @(posedge clk)
    begin
        d_neg_reg <= c_neg_reg;
        d_ql_reg  <= c_pl[RECIP_SHIFT +: 16];
        d_qr_reg  <= c_pr[RECIP_SHIFT +: 16];
    end

    assign d_tl = d_neg_reg ? -ACC_W'(d_ql_reg) : ACC_W'(d_ql_reg);
    assign d_tr = d_neg_reg ? -ACC_W'(d_qr_reg) : ACC_W'(d_qr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= cmd.walk_issue && a_play;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_clr)
        begin
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else if (d_vld_reg)
        begin
            accl_reg <= accl_reg + d_tl;
            accr_reg <= accr_reg + d_tr;
        end
    end

    // Saturation and active mask
    logic [15:0] sat_l;
    logic [15:0] sat_r;
    logic [31:0] mask_w;

    always_comb
    begin
        if (accl_reg > ACC_W'(OUT_MAX))
            sat_l = 16'(OUT_MAX);
        else if (accl_reg < ACC_W'(OUT_MIN))
            sat_l = 16'(OUT_MIN);
        else
            sat_l = accl_reg[15:0];
        if (accr_reg > ACC_W'(OUT_MAX))
            sat_r = 16'(OUT_MAX);
        else if (accr_reg < ACC_W'(OUT_MIN))
            sat_r = 16'(OUT_MIN);
        else
            sat_r = accr_reg[15:0];
    end

    always_comb
    begin
        mask_w = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (i < VOICES)
            begin
                mask_w[i] = active_reg[i];
            end
        end
    end

    // Output register
    logic        out_valid_reg;
    logic [15:0] out_left_reg;
    logic [15:0] out_right_reg;
    logic        out_frame_reg;
    logic [31:0] out_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_frame_reg <= (act_reg == ACT_TICK);
            out_left_reg  <= (act_reg == ACT_TICK) ? sat_l : 16'd0;
            out_right_reg <= (act_reg == ACT_TICK) ? sat_r : 16'd0;
            out_mask_reg  <= mask_w;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_left     = out_left_reg;
    assign out_right    = out_right_reg;
    assign out_is_frame = out_frame_reg;
    assign out_mask     = out_mask_reg;

    // Status
    assign sts.act       = act_reg;
    assign sts.walk_last = (32'(cnt_reg) == VOICES - 1);
    assign sts.pipe_busy = b_vld_reg || c_vld_reg || d_vld_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

[hw/rtl/multi_voice_sample_mixer_unit.sv]
// Load, gain and stop are captured, then applied in EXEC; a query goes via EXEC and RES.
// Start passes EXEC and START: the step comes from a registered reciprocal multiply.
// Frame tick walks one voice per cycle through a 4-stage pipe, then drains it to a result.
// One transaction at a time; input taken again while a result waits in the output register.
// Reset (async, active low) clears all voice state; the sample store is not cleared.
module multi_voice_sample_mixer_unit
    import mvsm_pkg::*;
#(
    parameter int VOICES      = 32,
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // voice, sample_index, sample_byte, sample_length, sample_rate, left_gain, right_gain
    input  logic [71:0] s_axis_tdata,
    // action
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_out, right_out, playing_mask
    output logic [63:0] m_axis_tdata,
    // is_frame
    output logic [0:0]  m_axis_tuser
);

    cmd_t        cmd;
    sts_t        sts;
    logic [15:0] left_w;
    logic [15:0] right_w;
    logic        frame_w;
    logic [31:0] mask_w;

    mvsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mvsm_dpath #(
        .VOICES      (VOICES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_act       (s_axis_tuser),
        .in_voice     (s_axis_tdata[4:0]),
        .in_sidx      (s_axis_tdata[16:5]),
        .in_sbyte     (s_axis_tdata[24:17]),
        .in_slen      (s_axis_tdata[37:25]),
        .in_srate     (s_axis_tdata[53:38]),
        .in_lg        (s_axis_tdata[60:54]),
        .in_rg        (s_axis_tdata[67:61]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_left     (left_w),
        .out_right    (right_w),
        .out_is_frame (frame_w),
        .out_mask     (mask_w)
    );

    assign m_axis_tdata = {mask_w, right_w, left_w};
    assign m_axis_tuser = frame_w;

endmodule

[hw/rtl/mvsm_checker.sv]
module mvsm_checker
    import mvsm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // One transaction in flight: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // Status query carries no audio
    a_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("query result with nonzero mix");

    // A load transaction never produces a result next cycle
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_LOAD && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result appeared after a load");

endmodule

bind multi_voice_sample_mixer_unit mvsm_checker u_mvsm_checker (.*);

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mvsm_pkg::*;

    localparam int NV   = 32;
    localparam int NS   = 4096;
    localparam int RATE = 11025;

    typedef struct packed {
        logic [2:0]  act;
        logic [4:0]  voice;
        logic [11:0] sidx;
        logic [7:0]  sbyte;
        logic [12:0] slen;
        logic [15:0] srate;
        logic [6:0]  lg;
        logic [6:0]  rg;
    } mix_item_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               is_frame;
        logic [31:0]        mask;
    } mix_out_t;

    // Directed row: item plus an optional typed-in result
    typedef struct packed {
        mix_item_t it;
        logic      typed;
        mix_out_t  res;
    } mix_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    multi_voice_sample_mixer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Mixer state mirror
    logic        mir_active [NV];
    logic [31:0] mir_pos    [NV];
    logic [31:0] mir_step   [NV];
    logic [12:0] mir_len    [NV];
    logic [6:0]  mir_lgain  [NV];
    logic [6:0]  mir_rgain  [NV];
    logic [7:0]  mir_store  [NV*NS];
    bit          mir_written[NV*NS];

    mix_out_t    pending_mixes[$];
    int          errors;
    int          send_idle;
    int          recv_idle;
    bit          recv_hold;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Timeout
    initial
    begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] playing_bits();
        logic [31:0] m;
        m = '0;
        for (int v = 0; v < NV; v++)
            m[v] = mir_active[v];
        return m;
    endfunction

    function automatic logic signed [15:0] clip16(int s);
        if (s > OUT_MAX)
            return 16'sh7FFF;
        if (s < OUT_MIN)
            return 16'sh8000;
        return s[15:0];
    endfunction

    // Advance the mirror by one item; returns 1 when a result is due
    function automatic bit mix_predict(mix_item_t it, output mix_out_t r);
        int acc_l;
        int acc_r;
        int centered;
        int idx;
        logic [12:0] len;
        r = '0;
        case (it.act)
            ACT_LOAD:
            begin
                mir_store[it.voice*NS + it.sidx]   = it.sbyte;
                mir_written[it.voice*NS + it.sidx] = 1'b1;
            end
            ACT_START:
            begin
                if (it.slen != 0)
                begin
                    len = (it.slen > NS) ? 13'(NS) : it.slen;
                    mir_len[it.voice]    = len;
                    mir_pos[it.voice]    = '0;
                    mir_step[it.voice]   = ({16'd0, it.srate} << FRAC_BITS) / RATE;
                    mir_lgain[it.voice]  = it.lg;
                    mir_rgain[it.voice]  = it.rg;
                    mir_active[it.voice] = 1'b1;
                end
            end
            ACT_GAIN:
            begin
                mir_lgain[it.voice] = it.lg;
                mir_rgain[it.voice] = it.rg;
            end
            ACT_STOP:
                mir_active[it.voice] = 1'b0;
            ACT_TICK:
            begin
                acc_l = 0;
                acc_r = 0;
                for (int v = 0; v < NV; v++)
                begin
                    if (mir_active[v])
                    begin
                        idx = int'(mir_pos[v] >> FRAC_BITS);
                        if (idx >= mir_len[v])
                            mir_active[v] = 1'b0;
                        else
                        begin
                            centered = (int'(mir_store[v*NS + idx]) - 128) * 256;
                            acc_l += (centered * int'(mir_lgain[v])) / 127;
                            acc_r += (centered * int'(mir_rgain[v])) / 127;
                            mir_pos[v] += mir_step[v];
                        end
                    end
                end
                r.left     = clip16(acc_l);
                r.right    = clip16(acc_r);
                r.is_frame = 1'b1;
                r.mask     = playing_bits();
                return 1;
            end
            ACT_QUERY:
            begin
                r.mask = playing_bits();
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    // One input transaction; prediction taken at acceptance
    task automatic offer(mix_item_t it, bit typed, mix_out_t res);
        mix_out_t r;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.act;
        s_axis_tdata  = {4'd0, it.rg, it.lg, it.srate, it.slen, it.sbyte, it.sidx, it.voice};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mix_predict(it, r))
            pending_mixes.push_back(typed ? res : r);
        @(negedge clk);
    endtask

    // Ticks first fill any store entry the frame would read unwritten
    task automatic send_item(mix_item_t it, bit typed, mix_out_t res);
        mix_item_t ld;
        int idx;
        if (it.act == ACT_TICK)
        begin
            for (int v = 0; v < NV; v++)
            begin
                idx = int'(mir_pos[v] >> FRAC_BITS);
                if (mir_active[v] && idx < mir_len[v] && !mir_written[v*NS + idx])
                begin
                    ld       = mix_item_t'({$urandom, $urandom, $urandom});
                    ld.act   = ACT_LOAD;
                    ld.voice = 5'(v);
                    ld.sidx  = 12'(idx);
                    offer(ld, 1'b0, '0);
                end
            end
        end
        offer(it, typed, res);
    endtask

    function automatic mix_item_t rand_item();
        mix_item_t it;
        int sel;
        it     = mix_item_t'({$urandom, $urandom, $urandom});
        it.voice = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(5));
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            it.act  = ACT_LOAD;
            if ($urandom_range(3) != 0)
                it.sidx = 12'($urandom_range(40));
        end
        else if (sel < 45)
        begin
            it.act = ACT_START;
            if ($urandom_range(9) != 0)
                it.slen = 13'($urandom_range(40));
            if ($urandom_range(4) == 0)
                it.srate = 16'($urandom_range(RATE * 2));
        end
        else if (sel < 52)
            it.act = ACT_GAIN;
        else if (sel < 57)
            it.act = ACT_STOP;
        else if (sel < 90)
            it.act = ACT_TICK;
        else if (sel < 97)
            it.act = ACT_QUERY;
        else
            it.act = 3'($urandom_range(6, 7));
        return it;
    endfunction

    // Receiver readiness
    always @(negedge clk)
    begin
        if (recv_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checking
    always @(posedge clk)
    begin
        mix_out_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_mixes.size() == 0)
            begin
                $error("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = pending_mixes.pop_front();
                if (m_axis_tdata[15:0] !== e.left)
                begin
                    $error("left_out exp %0d got %0d", e.left, $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (m_axis_tdata[31:16] !== e.right)
                begin
                    $error("right_out exp %0d got %0d", e.right,
                           $signed(m_axis_tdata[31:16]));
                    errors++;
                end
                if (m_axis_tuser[0] !== e.is_frame)
                begin
                    $error("is_frame exp %0b got %0b", e.is_frame, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.mask)
                begin
                    $error("playing_mask exp %h got %h", e.mask, m_axis_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    task automatic hold_receiver(int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(negedge clk);
        recv_hold = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_mixes.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    mix_row_t directed[$];

    function automatic mix_row_t row(logic [2:0] a, int v, int ix, int b, int len, int rt,
                                     int lg, int rg, bit typed, int l, int r, bit f,
                                     logic [31:0] m);
        mix_row_t d;
        d.it     = '{a, 5'(v), 12'(ix), 8'(b), 13'(len), 16'(rt), 7'(lg), 7'(rg)};
        d.typed  = typed;
        d.res    = '{16'(l), 16'(r), f, m};
        return d;
    endfunction

    initial
    begin
        mix_out_t none;
        errors        = 0;
        none          = '0;
        send_idle     = 20;
        recv_idle     = 54;
        recv_hold     = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_LOAD;
        m_axis_tready = 1'b0;
        for (int v = 0; v < NV; v++)
        begin
            mir_active[v] = 1'b0;
            mir_pos[v]    = '0;
            mir_step[v]   = '0;
            mir_len[v]    = '0;
            mir_lgain[v]  = '0;
            mir_rgain[v]  = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, extremes, saturation, ignored items
        directed = '{
            row(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'h0),
            row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 32'h0),
            row(ACT_LOAD, 0, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_LOAD, 1, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_LOAD, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_LOAD, 31, 4095, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_START, 0, 0, 0, 1, 0, 127, 127, 0, 0, 0, 0, 0),
            row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 32512, 32512, 1, 32'h1),
            row(ACT_START, 1, 0, 0, 1, 0, 127, 0, 0, 0, 0, 0, 0),
            row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 32767, 32512, 1, 32'h3),
            row(ACT_START, 2, 0, 0, 0, 65535, 127, 127, 0, 0, 0, 0, 0),
            row(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'h3),
            row(ACT_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_STOP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_GAIN, 31, 0, 0, 0, 0, 5, 6, 0, 0, 0, 0, 0),
            row(ACT_START, 31, 0, 0, 8191, 65535, 127, 127, 0, 0, 0, 0, 0),
            row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1, -32768, -32768, 1, 32'h80000000),
            row(ACT_GAIN, 31, 0, 0, 0, 0, 1, 64, 0, 0, 0, 0, 0),
            row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(3'd6, 31, 4095, 255, 8191, 65535, 127, 127, 0, 0, 0, 0, 0),
            row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_STOP, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ACT_QUERY, 17, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'h0)
        };
        foreach (directed[i])
            send_item(directed[i].it, directed[i].typed, directed[i].res);
        s_axis_tvalid = 1'b0;
        drain();

        // Random phases: receiver idles more, then sender idles more, then neither
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 20 : (ph == 1) ? 54 : 0;
            recv_idle = (ph == 0) ? 54 : (ph == 1) ? 20 : 0;
            for (int n = 0; n < 170; n++)
            begin
                if (ph == 0 && n == 60)
                    fork
                        hold_receiver(400);
                    join_none
                send_item(rand_item(), 1'b0, none);
            end
            s_axis_tvalid = 1'b0;
            drain();
        end

        repeat (80) @(posedge clk);
        if (errors == 0 && pending_mixes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
